FILE: hdl/thst_pkg.sv
// thst_pkg: shared constants, hash multipliers, mode codes and types of the tag/slot table
// used by every module of tag_slot_hash_table_unit but thst_ram; depends on nothing
package thst_pkg;

	// table geometry
	localparam int TABLE_SIZE = 1024;
	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int CNT_W      = IDX_W + 1;
	localparam int SLOT_W     = 10;
	localparam int TAG_W      = 31;
	localparam int MODE_W     = 2;
	localparam int HASH_W     = 32;
	localparam int ENTRY_W    = TAG_W + 1;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// multiplicative hash: h = h * a + tag, a = a * step, three rounds from h = 0
	localparam logic [HASH_W-1:0]   HASH_MUL_INIT = 32'd63689;
	localparam logic [HASH_W-1:0]   HASH_MUL_STEP = 32'd378551;
	localparam logic [2*HASH_W-1:0] HASH_PROD_R1  =
		{32'd0, HASH_MUL_INIT} * {32'd0, HASH_MUL_STEP};
	localparam logic [HASH_W-1:0]   HASH_MUL_R1   = HASH_PROD_R1[HASH_W-1:0];
	localparam logic [2*HASH_W-1:0] HASH_PROD_R2  =
		{32'd0, HASH_MUL_R1} * {32'd0, HASH_MUL_STEP};
	localparam logic [HASH_W-1:0]   HASH_MUL_R2   = HASH_PROD_R2[HASH_W-1:0];

	// request modes; the unused code behaves as a lookup
	typedef enum logic [MODE_W-1:0] {
		MODE_OPEN   = 2'd0,
		MODE_CLOSE  = 2'd1,
		MODE_LOOKUP = 2'd2
	} mode_t;

	// hashed request handed from front to back
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [TAG_W-1:0]  tag;
		logic [IDX_W-1:0]  start;
	} item_t;

	// back end sequencer
	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_PROBE
	} back_state_t;

endpackage

FILE: hdl/thst_ram.sv
// thst_ram: generic single-port RAM, one read or write per cycle, registered read data
// depends on nothing
module thst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write, or read into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

FILE: hdl/thst_front.sv
// thst_front: accepts requests and computes the start slot in a two-stage hash pipeline
// depends on thst_pkg
module thst_front import thst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [MODE_W-1:0] mode,
	input  logic [TAG_W-1:0]  tag,
	input  logic              clearing,
	output logic              push_valid,
	output item_t             push_item,
	input  logic              push_ready
);

	logic              valid_s1, valid_s2;
	logic [MODE_W-1:0] mode_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic [HASH_W-1:0] h1_s1;
	item_t             item_s2;
	logic              adv_s1, adv_s2, take;
	logic [HASH_W-1:0] tag_ext, tag_ext_s1, h1, h2;

	// elastic advance, no intake while the table is being cleared
	assign adv_s2   = !valid_s2 || push_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign take     = in_valid && !clearing;
	assign in_stall = !adv_s1 || clearing;

	// first two rounds, then the third round
	assign tag_ext    = {1'b0, tag};
	assign tag_ext_s1 = {1'b0, tag_s1};
	assign h1         = tag_ext * HASH_MUL_R1 + tag_ext;
	assign h2         = h1_s1 * HASH_MUL_R2 + tag_ext_s1;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= take;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv_s1 && take) begin
			mode_s1 <= mode;
			tag_s1  <= tag;
			h1_s1   <= h1;
		end
		if (adv_s2 && valid_s1) begin
			item_s2.mode  <= mode_s1;
			item_s2.tag   <= tag_s1;
			item_s2.start <= h2[IDX_W-1:0];
		end
	end

	assign push_valid = valid_s2;
	assign push_item  = item_s2;

endmodule

FILE: hdl/thst_queue.sv
// thst_queue: short flop queue of hashed requests between front and back
// depends on thst_pkg
module thst_queue import thst_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	input  item_t push_item,
	output logic  push_ready,
	output logic  pop_valid,
	output item_t pop_item,
	input  logic  pop
);

	item_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push, do_pop;

	assign push_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_item   = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

FILE: hdl/thst_back.sv
// thst_back: clears the table after reset, probes slots linearly, updates them, holds the result
// depends on thst_pkg and thst_ram
module thst_back import thst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	input  item_t             pop_item,
	output logic              pop,
	output logic              clearing,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SLOT_W-1:0] slot,
	output logic              hit,
	output logic              table_full
);

	back_state_t        state_q, state_d;
	item_t              cur_q;
	logic [IDX_W-1:0]   idx_q, clr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q, hit_q, full_q;
	logic [SLOT_W-1:0]  slot_q;

	logic               ram_en, ram_we;
	logic [IDX_W-1:0]   ram_addr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

	logic               used, match, last, out_free, start_item, step, load_out;

	// each entry holds the used mark above the tag
	thst_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_SIZE)
	) u_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	assign used     = ram_rdata[TAG_W];
	assign match    = !used || (ram_rdata[TAG_W-1:0] == cur_q.tag);
	assign last     = cnt_q == CNT_W'(TABLE_SIZE - 1);
	assign out_free = !out_valid_q || !out_stall;
	assign clearing = state_q == BK_CLEAR;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state, ram access, queue pop
	always_comb begin
		state_d    = state_q;
		ram_en     = 1'b0;
		ram_we     = 1'b0;
		ram_addr   = idx_q;
		ram_wdata  = '0;
		pop        = 1'b0;
		start_item = 1'b0;
		step       = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				ram_en   = 1'b1;
				ram_we   = 1'b1;
				ram_addr = clr_q;
				if (clr_q == IDX_W'(TABLE_SIZE - 1)) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (pop_valid) begin
					pop        = 1'b1;
					start_item = 1'b1;
					ram_en     = 1'b1;
					ram_addr   = pop_item.start;
					state_d    = BK_PROBE;
				end
			end
			BK_PROBE: begin
				if (match || last) begin
					if (out_free) begin
						load_out = 1'b1;
						state_d  = BK_IDLE;
						// open marks the slot, close clears it, other modes leave it
						if (match && (cur_q.mode == MODE_OPEN || cur_q.mode == MODE_CLOSE)) begin
							ram_en    = 1'b1;
							ram_we    = 1'b1;
							ram_wdata = {cur_q.mode == MODE_OPEN, cur_q.tag};
						end
					end
				end else begin
					step     = 1'b1;
					ram_en   = 1'b1;
					ram_addr = idx_q + 1'b1;
				end
			end
			default: begin
				state_d = BK_CLEAR;
			end
		endcase
	end

	// clear counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// probe position and result payload
	always_ff @(posedge clk) begin
		if (start_item) begin
			cur_q <= pop_item;
			idx_q <= pop_item.start;
			cnt_q <= '0;
		end else if (step) begin
			idx_q <= idx_q + 1'b1;
			cnt_q <= cnt_q + 1'b1;
		end
		if (load_out) begin
			if (match) begin
				slot_q <= SLOT_W'(idx_q);
				hit_q  <= used;
				full_q <= 1'b0;
			end else begin
				slot_q <= SLOT_W'(cur_q.start);
				hit_q  <= 1'b0;
				full_q <= 1'b1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign slot       = slot_q;
	assign hit        = hit_q;
	assign table_full = full_q;

endmodule

FILE: hdl/tag_slot_hash_table_unit.sv
// tag_slot_hash_table_unit: open-addressing tag to slot table with linear probing
// depends on thst_pkg, thst_front, thst_queue, thst_back (and thst_ram below it)
//
//  channel | handshake           | fields
//  --------+---------------------+--------------------------------
//  in      | in_valid / in_stall | mode[1:0], tag[30:0]
//  out     | out_valid/out_stall | slot[9:0], hit, table_full
//
// the hash is computed in front pipeline stages s1 and s2, then the request waits in a two-entry queue
// back end: BK_IDLE issues the first slot read, then BK_PROBE checks the probed slot and reads the next one
// until a slot matches or the last slot is reached
// the single-port table memory sets the rate: one slot is read or written per cycle
// after reset a clearing pass writes every table slot with in_stall high
// out_stall holds the result register; the front keeps taking transactions until the queue and the front stages fill
module tag_slot_hash_table_unit import thst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [MODE_W-1:0] mode,
	input  logic [TAG_W-1:0]  tag,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SLOT_W-1:0] slot,
	output logic              hit,
	output logic              table_full
);

	logic  push_valid, push_ready, pop_valid, pop, clearing;
	item_t push_item, pop_item;

	// hash front end
	thst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.tag       (tag),
		.clearing  (clearing),
		.push_valid(push_valid),
		.push_item (push_item),
		.push_ready(push_ready)
	);

	// decoupling queue
	thst_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_item (push_item),
		.push_ready(push_ready),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.pop       (pop)
	);

	// probe back end
	thst_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.pop       (pop),
		.clearing  (clearing),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.slot      (slot),
		.hit       (hit),
		.table_full(table_full)
	);

endmodule

FILE: hdl/thst_checker.sv
// thst_checker: port-level assertions for tag_slot_hash_table_unit, attached by bind
// depends on thst_pkg
module thst_checker import thst_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [SLOT_W-1:0] slot,
	input logic              hit,
	input logic              table_full
);

	logic [3:0] pending_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// transactions taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc && !out_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// no result without an earlier request
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("result with no request outstanding");

	// a full table never reports a hit
	a_full_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && table_full))
		else $error("hit and table_full together");

	// stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn under stall");

	// stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(slot) && $stable(hit) && $stable(table_full))
		else $error("result changed under stall");

endmodule

bind tag_slot_hash_table_unit thst_checker u_thst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.slot      (slot),
	.hit       (hit),
	.table_full(table_full)
);
